[src/arp_neighbor_cache_unit_assert.svh]
// Assertion macros shared by the checker of the neighbor cache unit.
`ifndef ARP_NEIGHBOR_CACHE_UNIT_ASSERT_SVH
`define ARP_NEIGHBOR_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ANC_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ANC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/anc_pkg.sv]
// Types and constants of the neighbor cache unit.
package anc_pkg;

    typedef enum logic [2:0] {
        ACT_LOOKUP  = 3'd0,
        ACT_ENTER   = 3'd1,
        ACT_RESOLVE = 3'd2,
        ACT_DELETE  = 3'd3,
        ACT_FLUSH   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        RC_RESOLVED = 3'd0,
        RC_WAITING  = 3'd1,
        RC_ENTERED  = 3'd2,
        RC_IGNORED  = 3'd3,
        RC_DONE     = 3'd4
    } t_rc;

    typedef enum logic [1:0] {
        EST_UNUSED = 2'd0,
        EST_OK     = 2'd1,
        EST_WAIT   = 2'd2
    } t_est;

    localparam logic [31:0] AGE_LIMIT_RST = 32'd900000;
    localparam logic [3:0]  MAC_LEN_ETH   = 4'd6;

    typedef struct packed {
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [47:0] mac;
        logic [1:0]  link_id;
        logic [1:0]  state;
        logic        listed;
        logic [31:0] use_time;
        logic [31:0] confirm_time;
    } t_entry;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [1:0]  medium_id;
        logic [47:0] mac_in;
        logic [3:0]  mac_length;
        logic        refresh_only;
        logic [7:0]  entry_select;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_code;
        logic        found;
        logic [7:0]  entry_index;
        logic [47:0] mac_out;
        logic        aged_out;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clear_track;
        logic rd_scan;
        logic rd_sel;
        logic wr_clear;
        logic fin;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_scan;
        logic is_sel;
        logic is_flush;
        logic out_busy;
    } t_stat;

endpackage

[src/anc_if.sv]
// Request and response channel interfaces of the neighbor cache unit.
interface anc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [1:0]  medium_id;
    logic [47:0] mac_in;
    logic [3:0]  mac_length;
    logic        refresh_only;
    logic [7:0]  entry_select;
    logic [31:0] now_time;

    modport source (output valid, action, ip_high, ip_low, medium_id, mac_in, mac_length,
                    refresh_only, entry_select, now_time, input ready);
    modport sink (input valid, action, ip_high, ip_low, medium_id, mac_in, mac_length,
                  refresh_only, entry_select, now_time, output ready);
endinterface

interface anc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_code;
    logic        found;
    logic [7:0]  entry_index;
    logic [47:0] mac_out;
    logic        aged_out;

    modport source (output valid, result_code, found, entry_index, mac_out, aged_out,
                    input ready);
    modport sink (input valid, result_code, found, entry_index, mac_out, aged_out,
                  output ready);
endinterface

[src/arp_neighbor_cache_unit.sv]
// Address-resolution cache of ENTRIES entries, one request at a time. Lookup, delete and
// enter with a six-byte address scan every entry once, one memory read per cycle; resolve
// reads the selected entry when it lies in range, and ignored requests and flush go on to
// the finish. Flush and reset run a clearing pass through every entry of the memory, during
// which no request is taken. A finished result sits in an output register until
// transferred; the next request is taken meanwhile, but its result waits for the register.
module arp_neighbor_cache_unit #(
    parameter int ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    anc_req_if.sink     i_req,
    anc_rsp_if.source   o_rsp
);
    import anc_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    t_cmd          cmd;
    t_stat         stat;
    t_req          req;
    t_rsp          rsp;
    logic [AW-1:0] addr;
    logic          in_ready;

    assign req.action       = i_req.action;
    assign req.ip_high      = i_req.ip_high;
    assign req.ip_low       = i_req.ip_low;
    assign req.medium_id    = i_req.medium_id;
    assign req.mac_in       = i_req.mac_in;
    assign req.mac_length   = i_req.mac_length;
    assign req.refresh_only = i_req.refresh_only;
    assign req.entry_select = i_req.entry_select;
    assign req.now_time     = i_req.now_time;
    assign i_req.ready      = in_ready;

    anc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    anc_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req),
        .i_cmd         (cmd),
        .i_addr        (addr),
        .o_stat        (stat),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_rsp         (rsp)
    );

    assign o_rsp.result_code = rsp.result_code;
    assign o_rsp.found       = rsp.found;
    assign o_rsp.entry_index = rsp.entry_index;
    assign o_rsp.mac_out     = rsp.mac_out;
    assign o_rsp.aged_out    = rsp.aged_out;
endmodule

[src/anc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module anc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/anc_ctrl.sv]
// Sequencer: clearing pass, scan over all entries, indexed read, write-back.
module anc_ctrl #(
    parameter int ENTRIES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  anc_pkg::t_stat             i_stat,
    output anc_pkg::t_cmd              o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_addr
);
    import anc_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DISP, S_SCAN, S_LAST, S_RSEL, S_RWAIT, S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_clear = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.clear_track = 1'b1;
                n_cnt = '0;
                if (i_stat.is_scan) begin
                    n_state = S_SCAN;
                end else if (i_stat.is_sel) begin
                    n_state = S_RSEL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_scan = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = S_LAST;
                end
            end
            S_LAST:  n_state = S_FIN;
            S_RSEL: begin
                o_cmd.rd_sel = 1'b1;
                n_state = S_RWAIT;
            end
            S_RWAIT: n_state = S_FIN;
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_cnt   = '0;
                    n_state = i_stat.is_flush ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_addr     = r_cnt;
endmodule

[src/anc_datapath.sv]
// Entry memory, scan trackers, entry update and result register.
module anc_datapath #(
    parameter int ENTRIES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [31:0]                i_cfg_wr_data,
    input  anc_pkg::t_req              i_req,
    input  anc_pkg::t_cmd              i_cmd,
    input  logic [$clog2(ENTRIES)-1:0] i_addr,
    output anc_pkg::t_stat             o_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output anc_pkg::t_rsp              o_rsp
);
    import anc_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int EW = $bits(t_entry);

    logic [31:0]   r_age;
    t_req          r_item;
    logic          r_hit, r_vany, r_rv, r_ov;
    logic [AW-1:0] r_midx, r_vidx, r_ridx;
    t_entry        r_mrec, r_vrec;
    t_rsp          r_rsp;

    logic [AW-1:0] raddr, waddr, fin_addr, sel_addr;
    logic [EW-1:0] rdata, wdata;
    logic          we, fin_we, sel_ok, match, ipm;
    t_entry        rd_e, fin_e;
    t_rsp          fin_rsp;

    assign sel_addr = AW'(r_item.entry_select);
    assign sel_ok   = ({24'd0, r_item.entry_select} < ENTRIES);
    assign raddr    = i_cmd.rd_sel ? sel_addr : i_addr;
    assign we       = i_cmd.wr_clear | (i_cmd.fin & fin_we);
    assign waddr    = i_cmd.wr_clear ? i_addr : fin_addr;
    assign wdata    = i_cmd.wr_clear ? '0 : EW'(fin_e);

    anc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // match test on the entry that arrives from the scan
    always_comb begin
        rd_e  = t_entry'(rdata);
        ipm   = rd_e.listed && (rd_e.ip_high == r_item.ip_high)
                && (rd_e.ip_low == r_item.ip_low);
        case (r_item.action)
            ACT_LOOKUP:  match = ipm && (rd_e.link_id == r_item.medium_id);
            ACT_ENTER:   match = ipm && (rd_e.link_id == r_item.medium_id)
                                 && (rd_e.state == EST_OK || rd_e.state == EST_WAIT);
            ACT_DELETE:  match = ipm;
            ACT_RESOLVE: match = 1'b1;
            default:     match = 1'b0;
        endcase
    end

    // entry update and result for the item
    always_comb begin
        fin_e    = r_mrec;
        fin_addr = r_midx;
        fin_we   = 1'b0;
        fin_rsp  = '0;
        fin_rsp.result_code = RC_IGNORED;
        case (r_item.action)
            ACT_LOOKUP: begin
                fin_we = 1'b1;
                if (r_hit) begin
                    fin_rsp.found = 1'b1;
                    fin_e.use_time = r_item.now_time;
                    if (r_mrec.state == EST_WAIT) begin
                        fin_rsp.result_code = RC_WAITING;
                    end else begin
                        fin_rsp.result_code = RC_RESOLVED;
                        fin_rsp.mac_out = r_mrec.mac;
                        if ((r_item.now_time - r_mrec.confirm_time) > r_age) begin
                            fin_e.use_time     = '0;
                            fin_e.confirm_time = '0;
                            fin_e.link_id      = '0;
                            fin_e.state        = EST_UNUSED;
                            fin_e.listed       = 1'b0;
                            fin_rsp.aged_out   = 1'b1;
                        end
                    end
                end else begin
                    fin_addr = r_vidx;
                    fin_e = r_vrec;
                    fin_e.ip_high      = r_item.ip_high;
                    fin_e.ip_low       = r_item.ip_low;
                    fin_e.link_id      = r_item.medium_id;
                    fin_e.listed       = 1'b1;
                    fin_e.use_time     = r_item.now_time;
                    fin_e.confirm_time = '0;
                    fin_e.state        = EST_WAIT;
                    fin_rsp.result_code = RC_WAITING;
                end
                fin_rsp.entry_index = 8'(fin_addr);
            end
            ACT_ENTER: begin
                if (r_item.mac_length == MAC_LEN_ETH && (r_hit || !r_item.refresh_only)) begin
                    fin_we = 1'b1;
                    if (!r_hit) begin
                        fin_addr = r_vidx;
                        fin_e = r_vrec;
                        fin_e.ip_high = r_item.ip_high;
                        fin_e.ip_low  = r_item.ip_low;
                        fin_e.link_id = r_item.medium_id;
                        fin_e.listed  = 1'b1;
                    end
                    fin_e.state        = EST_OK;
                    fin_e.mac          = r_item.mac_in;
                    fin_e.use_time     = r_item.now_time;
                    fin_e.confirm_time = r_item.now_time;
                    fin_rsp.result_code = RC_ENTERED;
                    fin_rsp.found       = r_hit;
                    fin_rsp.entry_index = 8'(fin_addr);
                end
            end
            ACT_RESOLVE: begin
                if (sel_ok) begin
                    fin_we   = 1'b1;
                    fin_addr = sel_addr;
                    fin_e.mac      = r_item.mac_in;
                    fin_e.link_id  = r_item.medium_id;
                    fin_e.state    = EST_OK;
                    fin_e.use_time = r_item.now_time;
                    fin_rsp.result_code = RC_RESOLVED;
                    fin_rsp.entry_index = r_item.entry_select;
                    fin_rsp.mac_out     = r_item.mac_in;
                end
            end
            ACT_DELETE: begin
                fin_rsp.result_code = RC_DONE;
                if (r_hit) begin
                    fin_we = 1'b1;
                    fin_e.listed  = 1'b0;
                    fin_e.ip_high = '0;
                    fin_e.ip_low  = '0;
                    fin_e.mac     = '0;
                    fin_rsp.found = 1'b1;
                    fin_rsp.entry_index = 8'(r_midx);
                end
            end
            ACT_FLUSH: fin_rsp.result_code = RC_DONE;
            default:   fin_rsp.result_code = RC_IGNORED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age  <= AGE_LIMIT_RST;
            r_hit  <= 1'b0;
            r_vany <= 1'b0;
            r_rv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_age <= i_cfg_wr_data;
            end
            r_rv <= i_cmd.rd_scan | i_cmd.rd_sel;
            if (i_cmd.clear_track) begin
                r_hit  <= 1'b0;
                r_vany <= 1'b0;
            end else if (r_rv) begin
                if (match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                // oldest use time, first index kept on ties
                if (!r_vany || rd_e.use_time < r_vrec.use_time) begin
                    r_vany <= 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= raddr;
        if (i_cmd.load) begin
            r_item <= i_req;
        end
        if (r_rv && !i_cmd.clear_track) begin
            if (match && !r_hit) begin
                r_midx <= r_ridx;
                r_mrec <= rd_e;
            end
            if (!r_vany || rd_e.use_time < r_vrec.use_time) begin
                r_vidx <= r_ridx;
                r_vrec <= rd_e;
            end
        end
        if (i_cmd.fin) begin
            r_rsp <= fin_rsp;
        end
    end

    assign o_stat.is_scan  = (r_item.action == ACT_LOOKUP) || (r_item.action == ACT_DELETE)
                             || (r_item.action == ACT_ENTER && r_item.mac_length == MAC_LEN_ETH);
    assign o_stat.is_sel   = (r_item.action == ACT_RESOLVE) && sel_ok;
    assign o_stat.is_flush = (r_item.action == ACT_FLUSH);
    assign o_stat.out_busy = r_ov && !i_out_ready;
    assign o_out_valid     = r_ov;
    assign o_rsp           = r_rsp;
endmodule

[src/arp_neighbor_cache_unit_chk.sv]
// Port-level checker of the neighbor cache unit and its bind.
`include "arp_neighbor_cache_unit_assert.svh"

module arp_neighbor_cache_unit_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_result_code,
    input logic        i_found,
    input logic [47:0] i_mac_out,
    input logic        i_aged_out
);
    import anc_pkg::*;

    // one request in flight: no transfer right after one
    `ANC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")
    `ANC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped before transfer")
    `ANC_ASSERT_NOW(a_aged_hit, i_clk, i_rst_n, i_out_valid && i_aged_out, i_found && i_result_code == RC_RESOLVED, "aged out without resolved hit")
    `ANC_ASSERT_NOW(a_mac_zero, i_clk, i_rst_n, i_out_valid && i_result_code != RC_RESOLVED, i_mac_out == 48'd0, "mac on unresolved result")
endmodule

bind arp_neighbor_cache_unit arp_neighbor_cache_unit_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_result_code (o_rsp.result_code),
    .i_found       (o_rsp.found),
    .i_mac_out     (o_rsp.mac_out),
    .i_aged_out    (o_rsp.aged_out)
);

[tb/arp_neighbor_cache_unit_test.sv]
// Self-checking testbench for the neighbor cache unit: directed table plus random traffic.
module arp_neighbor_cache_unit_test;
    import anc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENT      = 256;
    localparam int SETTLE     = N_ENT + 40;
    localparam int STALL_LIM  = 5000;
    localparam int RAND_ITEMS = 235;
    localparam int LONG_HOLD  = 1000;

    typedef struct {
        t_req r;
        bit   typed;
        t_rsp e;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    anc_req_if req_ch();
    anc_rsp_if rsp_ch();

    arp_neighbor_cache_unit #(.ENTRIES(N_ENT)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // predicted cache contents
    logic [63:0] ent_ip_hi  [N_ENT];
    logic [63:0] ent_ip_lo  [N_ENT];
    logic [47:0] ent_mac    [N_ENT];
    logic [1:0]  ent_medium [N_ENT];
    t_est        ent_state  [N_ENT];
    logic        ent_listed [N_ENT];
    logic [31:0] ent_used   [N_ENT];
    logic [31:0] ent_conf   [N_ENT];
    logic [31:0] age_limit_q;

    t_rsp        pending_rsp[$];
    int          mismatches;
    int          rsp_count;
    int          idle_cycles = 0;
    logic [63:0] pool_hi [8];
    logic [63:0] pool_lo [8];
    t_row        rows[$];

    function automatic void clear_cache();
        for (int i = 0; i < N_ENT; i++) begin
            ent_ip_hi[i]  = '0;
            ent_ip_lo[i]  = '0;
            ent_mac[i]    = '0;
            ent_medium[i] = '0;
            ent_state[i]  = EST_UNUSED;
            ent_listed[i] = 1'b0;
            ent_used[i]   = '0;
            ent_conf[i]   = '0;
        end
    endfunction

    // oldest use time wins, lowest index on ties
    function automatic int claim_entry(t_req r);
        int v;
        v = 0;
        for (int i = 1; i < N_ENT; i++)
            if (ent_used[i] < ent_used[v]) v = i;
        ent_ip_hi[v]  = r.ip_high;
        ent_ip_lo[v]  = r.ip_low;
        ent_listed[v] = 1'b1;
        ent_used[v]   = r.now_time;
        ent_conf[v]   = '0;
        ent_medium[v] = r.medium_id;
        return v;
    endfunction

    function automatic t_rsp cache_apply(t_req r);
        t_rsp o;
        bit   hit;
        int   k;
        o = '{result_code: RC_IGNORED, default: '0};
        hit = 1'b0;
        k = 0;
        case (t_action'(r.action))
            ACT_LOOKUP: begin
                for (int i = 0; i < N_ENT; i++)
                    if (!hit && ent_listed[i] && ent_ip_hi[i] == r.ip_high &&
                        ent_ip_lo[i] == r.ip_low && ent_medium[i] == r.medium_id) begin
                        hit = 1'b1;
                        k = i;
                    end
                if (!hit) begin
                    k = claim_entry(r);
                    ent_state[k] = EST_WAIT;
                end
                o.found = hit;
                o.entry_index = k[7:0];
                ent_used[k] = r.now_time;
                if (ent_state[k] == EST_WAIT) begin
                    o.result_code = RC_WAITING;
                end else begin
                    o.result_code = RC_RESOLVED;
                    o.mac_out = ent_mac[k];
                    if (32'(r.now_time - ent_conf[k]) > age_limit_q) begin
                        ent_used[k]   = '0;
                        ent_conf[k]   = '0;
                        ent_medium[k] = '0;
                        ent_state[k]  = EST_UNUSED;
                        ent_listed[k] = 1'b0;
                        o.aged_out    = 1'b1;
                    end
                end
            end
            ACT_ENTER: begin
                if (r.mac_length == MAC_LEN_ETH) begin
                    for (int i = 0; i < N_ENT; i++)
                        if (!hit && ent_listed[i] && ent_medium[i] == r.medium_id &&
                            (ent_state[i] == EST_OK || ent_state[i] == EST_WAIT) &&
                            ent_ip_hi[i] == r.ip_high && ent_ip_lo[i] == r.ip_low) begin
                            hit = 1'b1;
                            k = i;
                        end
                    if (hit) begin
                        ent_state[k] = EST_OK;
                        ent_mac[k]   = r.mac_in;
                        ent_used[k]  = r.now_time;
                        ent_conf[k]  = r.now_time;
                        o.result_code = RC_ENTERED;
                        o.found = 1'b1;
                        o.entry_index = k[7:0];
                    end else if (!r.refresh_only) begin
                        k = claim_entry(r);
                        ent_state[k] = EST_OK;
                        ent_conf[k]  = r.now_time;
                        ent_mac[k]   = r.mac_in;
                        o.result_code = RC_ENTERED;
                        o.entry_index = k[7:0];
                    end
                end
            end
            ACT_RESOLVE: begin
                if (int'(r.entry_select) < N_ENT) begin
                    k = int'(r.entry_select);
                    ent_mac[k]    = r.mac_in;
                    ent_medium[k] = r.medium_id;
                    ent_state[k]  = EST_OK;
                    ent_used[k]   = r.now_time;
                    o.result_code = RC_RESOLVED;
                    o.entry_index = r.entry_select;
                    o.mac_out     = r.mac_in;
                end
            end
            ACT_DELETE: begin
                o.result_code = RC_DONE;
                for (int i = 0; i < N_ENT; i++)
                    if (!hit && ent_listed[i] && ent_ip_hi[i] == r.ip_high &&
                        ent_ip_lo[i] == r.ip_low) begin
                        hit = 1'b1;
                        ent_listed[i] = 1'b0;
                        ent_ip_hi[i]  = '0;
                        ent_ip_lo[i]  = '0;
                        ent_mac[i]    = '0;
                        o.found = 1'b1;
                        o.entry_index = i[7:0];
                    end
            end
            ACT_FLUSH: begin
                clear_cache();
                o.result_code = RC_DONE;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_req mk_req(t_action a, logic [63:0] hi, logic [63:0] lo,
                                    logic [1:0] med, logic [47:0] mac, logic [3:0] len,
                                    logic rfr, logic [7:0] sel, logic [31:0] now);
        t_req r;
        r.action = a;
        r.ip_high = hi;
        r.ip_low = lo;
        r.medium_id = med;
        r.mac_in = mac;
        r.mac_length = len;
        r.refresh_only = rfr;
        r.entry_select = sel;
        r.now_time = now;
        return r;
    endfunction

    function automatic void add_row(t_req r, bit typed, t_rc rc = RC_IGNORED,
                                    logic fnd = 1'b0, logic [7:0] idx = 8'd0,
                                    logic [47:0] mac = 48'd0, logic aged = 1'b0);
        t_row w;
        w.r = r;
        w.typed = typed;
        w.e = '{result_code: rc, found: fnd, entry_index: idx, mac_out: mac, aged_out: aged};
        rows.push_back(w);
    endfunction

    // mostly a small pool of addresses so that hits, deletes and refreshes happen
    function automatic t_req rand_req(logic [31:0] now);
        t_req r;
        int   p;
        int   k;
        r.ip_high      = {$urandom, $urandom};
        r.ip_low       = {$urandom, $urandom};
        r.mac_in       = 48'({$urandom, $urandom});
        r.medium_id    = 2'($urandom_range(0, 3));
        r.mac_length   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : MAC_LEN_ETH;
        r.refresh_only = ($urandom_range(0, 3) == 0);
        r.entry_select = 8'($urandom_range(0, N_ENT - 1));
        r.now_time     = now;
        if ($urandom_range(0, 7) != 0) begin
            k = $urandom_range(0, 7);
            r.ip_high = pool_hi[k];
            r.ip_low  = pool_lo[k];
        end
        p = $urandom_range(0, 99);
        if (p < 35)      r.action = ACT_LOOKUP;
        else if (p < 65) r.action = ACT_ENTER;
        else if (p < 78) r.action = ACT_RESOLVE;
        else if (p < 92) r.action = ACT_DELETE;
        else if (p < 95) r.action = ACT_FLUSH;
        else             r.action = 3'($urandom_range(5, 7));
        return r;
    endfunction

    task automatic offer(t_req r, bit typed, t_rsp typed_rsp, int gap);
        t_rsp p;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= r.action;
        req_ch.ip_high      <= r.ip_high;
        req_ch.ip_low       <= r.ip_low;
        req_ch.medium_id    <= r.medium_id;
        req_ch.mac_in       <= r.mac_in;
        req_ch.mac_length   <= r.mac_length;
        req_ch.refresh_only <= r.refresh_only;
        req_ch.entry_select <= r.entry_select;
        req_ch.now_time     <= r.now_time;
        do @(posedge i_clk); while (!req_ch.ready);
        p = cache_apply(r);
        pending_rsp.push_back(typed ? typed_rsp : p);
    endtask

    task automatic drain_and_settle();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_age_limit(logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        age_limit_q = v;
    endtask

    // response side: random stalls, calm stretches, one long hold-off
    initial begin
        int   gap;
        t_rsp got;
        t_rsp want;
        rsp_ch.ready <= 1'b0;
        rsp_count = 0;
        mismatches = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ((rsp_count / 64) % 3 == 1) ? 0 : $urandom_range(0, 4);
            if (rsp_count == 120) gap = LONG_HOLD;
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            got = '{result_code: rsp_ch.result_code, found: rsp_ch.found,
                    entry_index: rsp_ch.entry_index, mac_out: rsp_ch.mac_out,
                    aged_out: rsp_ch.aged_out};
            rsp_count++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rc=%0d idx=%0d", got.result_code,
                             got.entry_index);
            end else begin
                want = pending_rsp.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: exp rc=%0d fnd=%0b idx=%0d mac=%h aged=%0b, got rc=%0d fnd=%0b idx=%0d mac=%h aged=%0b",
                                 rsp_count, want.result_code, want.found, want.entry_index,
                                 want.mac_out, want.aged_out, got.result_code, got.found,
                                 got.entry_index, got.mac_out, got.aged_out);
                end
            end
        end
    end

    // no transfer on either side for too long means a hang
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIM) begin
            $display("arp_neighbor_cache_unit test failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] now;
        logic [31:0] limits[4];
        logic [47:0] mac_a;
        logic [47:0] mac_x;
        logic [63:0] v4_lo;
        int          gap;
        i_rst_n      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.action <= ACT_LOOKUP;
        req_ch.ip_high <= '0;
        req_ch.ip_low <= '0;
        req_ch.medium_id <= '0;
        req_ch.mac_in <= '0;
        req_ch.mac_length <= '0;
        req_ch.refresh_only <= 1'b0;
        req_ch.entry_select <= '0;
        req_ch.now_time <= '0;
        clear_cache();
        age_limit_q = AGE_LIMIT_RST;
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        for (int i = 2; i < 8; i++) begin
            pool_hi[i] = (i < 6) ? 64'd0 : {$urandom, $urandom};
            pool_lo[i] = (i < 6) ? {32'h0000_ffff, 32'($urandom)} : {$urandom, $urandom};
        end
        mac_a = 48'h0200_1234_5678;
        mac_x = 48'({$urandom, $urandom});
        v4_lo = {32'h0000_ffff, 32'hc0a8_0101};

        add_row(mk_req(ACT_LOOKUP, 64'h1, 64'h2, 0, 0, 6, 0, 0, 100), 1, RC_WAITING, 0, 0);
        add_row(mk_req(ACT_LOOKUP, 64'h1, 64'h2, 0, 0, 6, 0, 0, 200), 1, RC_WAITING, 1, 0);
        add_row(mk_req(ACT_ENTER, 64'h1, 64'h2, 0, mac_a, 6, 0, 0, 300), 1, RC_ENTERED, 1, 0);
        add_row(mk_req(ACT_LOOKUP, 64'h1, 64'h2, 0, 0, 6, 0, 0, 400), 1, RC_RESOLVED, 1, 0,
                mac_a);
        add_row(mk_req(ACT_ENTER, '1, '1, 3, '1, 6, 0, 0, 500), 1, RC_ENTERED, 0, 1);
        // wrong address length and refresh without an entry are both no-ops
        add_row(mk_req(ACT_ENTER, 64'h0, v4_lo, 1, mac_x, 5, 0, 0, 550), 1);
        add_row(mk_req(ACT_ENTER, 64'h0, v4_lo, 1, mac_x, 15, 0, 0, 550), 1);
        add_row(mk_req(ACT_ENTER, 64'h0, v4_lo, 1, mac_x, 6, 1, 0, 560), 1);
        add_row(mk_req(ACT_RESOLVE, 0, 0, 2, mac_x, 0, 0, 8'd255, 600), 1, RC_RESOLVED, 0,
                8'd255, mac_x);
        // confirmed at 500, one past the default limit: answered, then cleaned
        add_row(mk_req(ACT_LOOKUP, '1, '1, 3, 0, 6, 0, 0, 900501), 1, RC_RESOLVED, 1, 1, '1,
                1);
        add_row(mk_req(ACT_LOOKUP, '1, '1, 3, 0, 6, 0, 0, 900600), 0);
        add_row(mk_req(ACT_DELETE, 64'h1, 64'h2, 2, 0, 6, 0, 0, 700), 1, RC_DONE, 1, 0);
        add_row(mk_req(ACT_DELETE, 64'h1, 64'h2, 0, 0, 6, 0, 0, 800), 1, RC_DONE, 0, 0);
        add_row(mk_req(t_action'(3'd5), 64'h1, 64'h2, 0, 0, 6, 0, 0, 900), 1);
        add_row(mk_req(t_action'(3'd6), '1, '1, 3, '1, 8, 1, '1, '1), 1);
        add_row(mk_req(t_action'(3'd7), 64'h1, 64'h2, 0, 0, 6, 0, 0, 900), 1);
        add_row(mk_req(ACT_LOOKUP, 64'h0, v4_lo, 1, 0, 6, 0, 0, '1), 0);
        add_row(mk_req(ACT_ENTER, 64'h0, v4_lo, 1, mac_x, 6, 1, 0, 32'hffff_fff0), 0);
        add_row(mk_req(ACT_LOOKUP, 64'h0, v4_lo, 1, 0, 6, 0, 0, 5), 0);
        add_row(mk_req(ACT_RESOLVE, '1, '1, 3, '1, '1, 1, 8'd0, 0), 0);
        add_row(mk_req(ACT_FLUSH, 64'h1, 64'h2, 0, 0, 6, 0, 0, 1000), 1, RC_DONE);
        add_row(mk_req(ACT_LOOKUP, 0, 0, 0, 0, 6, 0, 0, 0), 1, RC_WAITING, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[n])
            offer(rows[n].r, rows[n].typed, rows[n].e, $urandom_range(0, 4));

        limits[0] = 32'd0;
        limits[1] = '1;
        limits[2] = 32'd5000;
        limits[3] = $urandom;
        now = 32'd2000;
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_settle();
            write_age_limit(limits[ph]);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if ($urandom_range(0, 19) == 0)
                    now = $urandom;
                else
                    now = now + $urandom_range(0, 3000);
                gap = ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 4);
                offer(rand_req(now), 0, '0, gap);
            end
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("arp_neighbor_cache_unit test passed");
        else
            $display("arp_neighbor_cache_unit test failed");
        $finish;
    end
endmodule

[arp_neighbor_cache_unit.f]
+incdir+src
src/anc_pkg.sv
src/anc_if.sv
src/anc_ram.sv
src/anc_ctrl.sv
src/anc_datapath.sv
src/arp_neighbor_cache_unit.sv
src/arp_neighbor_cache_unit_chk.sv
tb/arp_neighbor_cache_unit_test.sv
